// ===== rtl/core/mfh_pkg.sv =====
// Shared types, constants and helpers for the multiply-fold hash block.
// Used by mfh_ctrl, mfh_datapath and multiply_fold_hash_32; no dependencies.
package mfh_pkg;

  // Fold multipliers
  localparam logic [31:0] MUL_M = 32'h5755_9429;
  localparam logic [31:0] MUL_N = 32'h5052_ACDB;

  // Input tdata layout, lowest bit first
  localparam int WORD_W  = 32;
  localparam int VB_W    = 3;
  localparam int SEED_W  = 32;
  localparam int LEN_W   = 32;
  localparam int FIELD_W = WORD_W + VB_W + SEED_W + LEN_W;
  localparam int S_TDATA_W = ((FIELD_W + 7) / 8) * 8;

  localparam int VB_LO   = WORD_W;
  localparam int SEED_LO = VB_LO + VB_W;
  localparam int LEN_LO  = SEED_LO + SEED_W;

  localparam int HASH_W = 32;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // input transfer: init on first word, select operand, multiply
    logic fold;      // xor product halves into h/k
    logic fin_op;    // form final operand h ^ (k + N)
    logic fin_mul;   // multiply final operand by N
    logic out_load;  // load output register with k ^ h
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } sts_t;

  // Keep the valid low bytes of a tail word
  function automatic logic [31:0] tail_mask(input logic [2:0] vb);
    logic [31:0] m;
    case (vb)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/mfh_ctrl.sv =====
// Sequencing FSM for the multiply-fold hash: one word fold per item, then finalization after the last.
// Depends on mfh_pkg (cmd_t, sts_t).
module mfh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tlast,
  output logic          s_axis_tready,
  input  mfh_pkg::sts_t sts,
  output mfh_pkg::cmd_t cmd
);
  import mfh_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FOLD     = 3'd1;
  localparam logic [2:0] S_FIN_OP   = 3'd2;
  localparam logic [2:0] S_FIN_MUL  = 3'd3;
  localparam logic [2:0] S_FIN_FOLD = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_q;
  logic       accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = last_q ? S_FIN_OP : S_IDLE;
      end
      S_FIN_OP: begin
        cmd.fin_op = 1'b1;
        state_next = S_FIN_MUL;
      end
      S_FIN_MUL: begin
        cmd.fin_mul = 1'b1;
        state_next  = S_FIN_FOLD;
      end
      S_FIN_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and last-item flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) last_q <= s_axis_tlast;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_fold: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_FOLD)
    else $error("accepted transfer not followed by fold");

  a_last_finalizes: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> ##1 state == S_FIN_OP)
    else $error("last item did not enter finalization");

  a_nonlast_returns: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_axis_tlast) |=> ##1 state == S_IDLE)
    else $error("non-last item did not return to idle");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while occupied");
`endif

endmodule

// ===== rtl/core/mfh_datapath.sv =====
// Hash datapath: h/k accumulators, shared registered 32x32 multiplier,
// output register. Depends on mfh_pkg (constants, cmd_t, sts_t, tail_mask).
module mfh_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mfh_pkg::cmd_t                 cmd,
  output mfh_pkg::sts_t                 sts,
  input  logic [mfh_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mfh_pkg::HASH_W-1:0]    m_axis_tdata
);
  import mfh_pkg::*;

  logic [31:0] acc_h;
  logic [31:0] acc_k;
  logic        odd_word;
  logic [31:0] fin_a;
  logic [63:0] prod;
  logic        sel_n;
  logic        do_fold;

  logic [31:0] in_word;
  logic [2:0]  in_vb;
  logic [31:0] in_seed;
  logic [31:0] in_len;
  logic        in_full;
  logic        odd_base;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_next;

  // Unpack the input transfer
  assign in_word = s_axis_tdata[VB_LO-1:0];
  assign in_vb   = s_axis_tdata[SEED_LO-1:VB_LO];
  assign in_seed = s_axis_tdata[LEN_LO-1:SEED_LO];
  assign in_len  = s_axis_tdata[FIELD_W-1:LEN_LO];

  // Counts of 4 and above are a full word
  assign in_full  = in_vb[2];
  assign odd_base = s_axis_tuser ? 1'b0 : odd_word;

  // Multiplier operands: input word or the final operand
  always_comb begin
    if (cmd.fin_mul) begin
      mul_a = fin_a;
      mul_b = MUL_N;
    end else begin
      mul_a = in_word & tail_mask(in_vb);
      mul_b = (in_full && !odd_base) ? MUL_N : MUL_M;
    end
  end

  assign prod_next = 64'(mul_a) * 64'(mul_b);

  // Accumulators and word parity
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_h    <= '0;
      acc_k    <= '0;
      odd_word <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (s_axis_tuser) begin
          acc_h <= in_len;
          acc_k <= in_len + in_seed + MUL_N;
        end
        odd_word <= in_full ? ~odd_base : odd_base;
      end
      if (cmd.fold && do_fold) begin
        if (sel_n) begin
          acc_h <= acc_h ^ prod[31:0];
          acc_k <= acc_k ^ prod[63:32];
        end else begin
          acc_k <= acc_k ^ prod[31:0];
          acc_h <= acc_h ^ prod[63:32];
        end
      end
      if (cmd.fin_op) odd_word <= 1'b0;
    end
  end

  // Product register and fold controls
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod    <= prod_next;
      sel_n   <= in_full && !odd_base;
      do_fold <= (in_vb != 3'd0);
    end else if (cmd.fin_mul) begin
      prod    <= prod_next;
      sel_n   <= 1'b1;
      do_fold <= 1'b1;
    end
    if (cmd.fin_op) fin_a <= acc_h ^ (acc_k + MUL_N);
  end

  // Output register
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_axis_tdata <= acc_k ^ acc_h;
  end

endmodule

// ===== rtl/core/multiply_fold_hash_32.sv =====
// Top level of the streaming multiply-fold 32-bit hash.
// Depends on mfh_pkg, mfh_ctrl and mfh_datapath.
//
// Channel   Dir  tdata (low bit first)                          tuser        tlast
// s_axis    in   data_word[31:0] valid_bytes[34:32]              first_word   last_word
//                seed[66:35] msg_length[98:67] zero[103:99]
// m_axis    out  hash_value[31:0]                               -            -
//
// An item that is not last is accepted with its multiply, then folded.
// A last item goes through accept, fold, final operand, final multiply,
// final fold and output load; the output load waits while the output register
// is held by a stalled sink. The shared registered 32x32 multiplier sets this order.
// Input is taken again while a result still waits on m_axis.
// rst is synchronous, active high; it clears h, k, word parity and the output valid.
module multiply_fold_hash_32 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mfh_pkg::S_TDATA_W-1:0] s_axis_tdata,  // data_word, valid_bytes, seed,
                                                      // msg_length, zero pad
  input  logic                          s_axis_tuser,  // first_word
  input  logic                          s_axis_tlast,  // last_word
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mfh_pkg::HASH_W-1:0]    m_axis_tdata   // hash_value
);
  import mfh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mfh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Accumulators, multiplier, output register
  mfh_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
